[hdl/gcc_pkg.sv]
// shared types and codes for the glauber collision counter
// no dependencies
package gcc_pkg;

	localparam logic [2:0] OP_WR_A   = 3'd0;
	localparam logic [2:0] OP_WR_B   = 3'd1;
	localparam logic [2:0] OP_EVENT  = 3'd2;
	localparam logic [2:0] OP_RD_A   = 3'd3;
	localparam logic [2:0] OP_RD_B   = 3'd4;

	localparam logic [2:0] REG_CROSS   = 3'd0;
	localparam logic [2:0] REG_COUNT_A = 3'd1;
	localparam logic [2:0] REG_COUNT_B = 3'd2;
	localparam logic [2:0] REG_ENTROPY = 3'd3;
	localparam logic [2:0] REG_ALPHA   = 3'd4;

	localparam logic [33:0] CROSS_RST   = 34'd1078985;
	localparam logic [8:0]  COUNT_RST   = 9'd197;
	localparam logic [15:0] ENTROPY_RST = 16'd256;
	localparam logic [16:0] ALPHA_RST   = 17'd0;
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;

	typedef struct packed {
		logic [33:0] cross_distance_sq;
		logic [8:0]  count_a;
		logic [8:0]  count_b;
		logic [15:0] entropy_per_wounded;
		logic [16:0] binary_fraction;
	} cfg_t;

endpackage

[hdl/glauber_collision_counter.sv]
// glauber collision counter: write items go straight to ram, read items pass S_RD1 to S_RD_OUT
// compute time is set by the hits_a read-modify-write loop, one pair a cycle, pipeline drained per row
// reset restores default settings, clears event counters and control; hit stores read as zero until first compute
// depends on gcc_pkg, gcc_ram, gcc_cfg, gcc_weight
module glauber_collision_counter #(
	parameter int MAX_NUCLEONS = 256,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [5:0]                    paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [7:0]                    slot,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [9:0]                    participants,
	output logic [16:0]                   binary_collisions,
	output logic                          event_ok,
	output logic [31:0]                   total_events,
	output logic [31:0]                   good_events,
	output logic [8:0]                    nucleon_collisions,
	output logic                          nucleon_wounded,
	output logic [23:0]                   nucleon_weight
);
	import gcc_pkg::*;

	localparam int AW    = (MAX_NUCLEONS > 1) ? $clog2(MAX_NUCLEONS) : 1;
	localparam int CNT_W = $clog2(MAX_NUCLEONS + 1);
	localparam int PW    = 2 * COORD_WIDTH;
	localparam int DW    = (COORD_WIDTH + 1 > 18) ? COORD_WIDTH + 1 : 18;
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_NUCLEONS - 1);
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_NUCLEONS);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CLEAR   = 4'd1;
	localparam logic [3:0] S_ROW_RD  = 4'd2;
	localparam logic [3:0] S_ROW_LD  = 4'd3;
	localparam logic [3:0] S_PAIR    = 4'd4;
	localparam logic [3:0] S_DRAIN   = 4'd5;
	localparam logic [3:0] S_SUM_A   = 4'd6;
	localparam logic [3:0] S_SUM_B   = 4'd7;
	localparam logic [3:0] S_SUM_END = 4'd8;
	localparam logic [3:0] S_EV_OUT  = 4'd9;
	localparam logic [3:0] S_RD1     = 4'd10;
	localparam logic [3:0] S_RD2     = 4'd11;
	localparam logic [3:0] S_RD3     = 4'd12;
	localparam logic [3:0] S_RD_OUT  = 4'd13;

	cfg_t cfg;

	gcc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	logic [3:0]       state_q;
	logic [CNT_W-1:0] idx_q, row_q, na, nb;
	logic             computed_q;
	logic             rd_b_q, rd_ok_q;
	logic [8:0]       n_q, hb_q;
	logic [PW-1:0]    pb_q;
	logic             sv_q, sb_q;
	logic [9:0]       part_q;
	logic [16:0]      coll_q;
	logic [31:0]      ev_cnt_q, good_cnt_q;
	logic             accept, out_free;
	logic [10:0]      slot_ext;
	logic             slot_ok;
	logic [AW-1:0]    slot_addr;
	logic [11:0]      ca_ext, cb_ext;

	// memory ports
	logic          pa_we, pb_we, ha_we, hb_we;
	logic [AW-1:0] pa_ra, pb_ra, ha_ra, hb_ra, ha_wa, hb_wa;
	logic [8:0]    ha_wd, hb_wd, ha_rd, hb_rd;
	logic [PW-1:0] pa_rd, pb_rd;

	// pair pipeline
	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	logic [16:0]   adx_s2, ady_s2;
	logic          far_s2, far_s3;
	logic [8:0]    ha_s2, ha_s3;
	logic [33:0]   sqx_s3, sqy_s3;
	logic signed [DW-1:0] ax, ay, bx, by, dx, dy;
	logic [DW-1:0] adx, ady;
	logic          hit;
	logic          pipe_empty;
	logic [17:0]   coll_sum;
	logic [23:0]   weight;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid || !out_stall;
	assign slot_ext  = {3'd0, slot};
	assign slot_ok   = slot_ext < 11'(MAX_NUCLEONS);
	assign slot_addr = slot_ext[AW-1:0];
	assign ca_ext    = {3'd0, cfg.count_a};
	assign cb_ext    = {3'd0, cfg.count_b};
	assign na = (ca_ext > 12'(MAX_NUCLEONS)) ? MAX_CNT : ca_ext[CNT_W-1:0];
	assign nb = (cb_ext > 12'(MAX_NUCLEONS)) ? MAX_CNT : cb_ext[CNT_W-1:0];
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	gcc_ram #(.WIDTH(PW), .DEPTH(MAX_NUCLEONS)) u_pos_a (
		.clk(clk), .we(pa_we), .waddr(slot_addr), .wdata({pos_y, pos_x}),
		.raddr(pa_ra), .rdata(pa_rd)
	);
	gcc_ram #(.WIDTH(PW), .DEPTH(MAX_NUCLEONS)) u_pos_b (
		.clk(clk), .we(pb_we), .waddr(slot_addr), .wdata({pos_y, pos_x}),
		.raddr(pb_ra), .rdata(pb_rd)
	);
	gcc_ram #(.WIDTH(9), .DEPTH(MAX_NUCLEONS)) u_hits_a (
		.clk(clk), .we(ha_we), .waddr(ha_wa), .wdata(ha_wd),
		.raddr(ha_ra), .rdata(ha_rd)
	);
	gcc_ram #(.WIDTH(9), .DEPTH(MAX_NUCLEONS)) u_hits_b (
		.clk(clk), .we(hb_we), .waddr(hb_wa), .wdata(hb_wd),
		.raddr(hb_ra), .rdata(hb_rd)
	);

	gcc_weight u_weight (.clk(clk), .cfg(cfg), .n(n_q), .weight(weight));

	assign hit = v_s3 && !far_s3 &&
		((35'(sqx_s3) + 35'(sqy_s3)) < 35'(cfg.cross_distance_sq));

	always_comb begin
		pa_we = accept && (opcode == OP_WR_A) && slot_ok;
		pb_we = accept && (opcode == OP_WR_B) && slot_ok;
		pa_ra = idx_q[AW-1:0];
		pb_ra = row_q[AW-1:0];
		ha_ra = (state_q == S_IDLE) ? slot_addr : idx_q[AW-1:0];
		hb_ra = (state_q == S_IDLE) ? slot_addr : idx_q[AW-1:0];
		if (state_q == S_CLEAR) begin
			ha_we = 1'b1;
			ha_wa = idx_q[AW-1:0];
			ha_wd = 9'd0;
			hb_we = 1'b1;
			hb_wa = idx_q[AW-1:0];
			hb_wd = 9'd0;
		end else begin
			ha_we = hit;
			ha_wa = addr_s3;
			ha_wd = (ha_s3 == 9'h1FF) ? ha_s3 : ha_s3 + 9'd1;
			hb_we = (state_q == S_DRAIN) && pipe_empty;
			hb_wa = row_q[AW-1:0];
			hb_wd = hb_q;
		end
	end

	// distance stage
	always_comb begin
		ax  = DW'($signed(pa_rd[COORD_WIDTH-1:0]));
		ay  = DW'($signed(pa_rd[PW-1:COORD_WIDTH]));
		bx  = DW'($signed(pb_q[COORD_WIDTH-1:0]));
		by  = DW'($signed(pb_q[PW-1:COORD_WIDTH]));
		dx  = bx - ax;
		dy  = by - ay;
		adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
		ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr_s1;
		adx_s2  <= adx[16:0];
		ady_s2  <= ady[16:0];
		far_s2  <= (|adx[DW-1:17]) || (|ady[DW-1:17]);
		ha_s2   <= ha_rd;
		addr_s3 <= addr_s2;
		sqx_s3  <= adx_s2 * adx_s2;
		sqy_s3  <= ady_s2 * ady_s2;
		far_s3  <= far_s2;
		ha_s3   <= ha_s2;
	end

	assign coll_sum = {1'b0, coll_q} + 18'(hb_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			row_q      <= '0;
			computed_q <= 1'b0;
			rd_b_q     <= 1'b0;
			rd_ok_q    <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			sv_q       <= 1'b0;
			sb_q       <= 1'b0;
			ev_cnt_q   <= 32'd0;
			good_cnt_q <= 32'd0;
			out_valid  <= 1'b0;
			hb_q       <= 9'd0;
			part_q     <= 10'd0;
			coll_q     <= 17'd0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s1 <= 1'b0;
			sv_q <= 1'b0;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (hit && hb_q != 9'h1FF) begin
				hb_q <= hb_q + 9'd1;
			end
			if (sv_q && (sb_q ? hb_rd : ha_rd) != 9'd0) begin
				part_q <= (part_q == 10'h3FF) ? part_q : part_q + 10'd1;
				if (sb_q) begin
					coll_q <= coll_sum[17] ? 17'h1FFFF : coll_sum[16:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_EVENT) begin
							idx_q   <= '0;
							state_q <= S_CLEAR;
						end else if (opcode == OP_RD_A || opcode == OP_RD_B) begin
							rd_b_q  <= (opcode == OP_RD_B);
							rd_ok_q <= slot_ok && computed_q;
							state_q <= S_RD1;
						end
					end
				end
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_SLOT) begin
						computed_q <= 1'b1;
						row_q      <= '0;
						idx_q      <= '0;
						part_q     <= 10'd0;
						coll_q     <= 17'd0;
						if (nb == '0) begin
							state_q <= (na == '0) ? S_SUM_END : S_SUM_A;
						end else begin
							state_q <= S_ROW_RD;
						end
					end
				end
				S_ROW_RD: begin
					state_q <= S_ROW_LD;
				end
				S_ROW_LD: begin
					pb_q    <= pb_rd;
					idx_q   <= '0;
					hb_q    <= 9'd0;
					state_q <= (na == '0) ? S_DRAIN : S_PAIR;
				end
				S_PAIR: begin
					v_s1    <= 1'b1;
					addr_s1 <= idx_q[AW-1:0];
					idx_q   <= idx_q + 1'b1;
					if (CNT_W'(idx_q + 1'b1) == na) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						row_q <= row_q + 1'b1;
						idx_q <= '0;
						if (CNT_W'(row_q + 1'b1) == nb) begin
							state_q <= (na == '0) ? S_SUM_B : S_SUM_A;
						end else begin
							state_q <= S_ROW_RD;
						end
					end
				end
				S_SUM_A: begin
					sv_q  <= 1'b1;
					sb_q  <= 1'b0;
					idx_q <= idx_q + 1'b1;
					if (CNT_W'(idx_q + 1'b1) == na) begin
						idx_q   <= '0;
						state_q <= (nb == '0) ? S_SUM_END : S_SUM_B;
					end
				end
				S_SUM_B: begin
					sv_q  <= 1'b1;
					sb_q  <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (CNT_W'(idx_q + 1'b1) == nb) begin
						state_q <= S_SUM_END;
					end
				end
				S_SUM_END: begin
					state_q <= S_EV_OUT;
				end
				S_EV_OUT: begin
					if (out_free) begin
						out_valid          <= 1'b1;
						participants       <= part_q;
						binary_collisions  <= coll_q;
						event_ok           <= (part_q != 10'd0);
						total_events       <= ev_cnt_q + 32'd1;
						good_events        <= good_cnt_q + 32'(part_q != 10'd0);
						nucleon_collisions <= 9'd0;
						nucleon_wounded    <= 1'b0;
						nucleon_weight     <= 24'd0;
						ev_cnt_q           <= ev_cnt_q + 32'd1;
						good_cnt_q         <= good_cnt_q + 32'(part_q != 10'd0);
						state_q            <= S_IDLE;
					end
				end
				S_RD1: begin
					n_q     <= rd_ok_q ? (rd_b_q ? hb_rd : ha_rd) : 9'd0;
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_RD3;
				end
				S_RD3: begin
					state_q <= S_RD_OUT;
				end
				S_RD_OUT: begin
					if (out_free) begin
						out_valid          <= 1'b1;
						participants       <= 10'd0;
						binary_collisions  <= 17'd0;
						event_ok           <= 1'b0;
						total_events       <= 32'd0;
						good_events        <= 32'd0;
						nucleon_collisions <= n_q;
						nucleon_wounded    <= (n_q != 9'd0);
						nucleon_weight     <= weight;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/gcc_ram.sv]
// generic single write port ram with registered read
// no dependencies
module gcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/gcc_cfg.sv]
// apb register file for the collision counter settings
// depends on gcc_pkg
module gcc_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	output gcc_pkg::cfg_t cfg
);
	import gcc_pkg::*;

	cfg_t        cfg_q;
	logic [2:0]  idx;

	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cross_distance_sq   <= CROSS_RST;
			cfg_q.count_a             <= COUNT_RST;
			cfg_q.count_b             <= COUNT_RST;
			cfg_q.entropy_per_wounded <= ENTROPY_RST;
			cfg_q.binary_fraction     <= ALPHA_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_CROSS:   cfg_q.cross_distance_sq   <= pwdata[33:0];
				REG_COUNT_A: cfg_q.count_a             <= pwdata[8:0];
				REG_COUNT_B: cfg_q.count_b             <= pwdata[8:0];
				REG_ENTROPY: cfg_q.entropy_per_wounded <= pwdata[15:0];
				REG_ALPHA:   cfg_q.binary_fraction     <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CROSS:   prdata = {30'd0, cfg_q.cross_distance_sq};
			REG_COUNT_A: prdata = {55'd0, cfg_q.count_a};
			REG_COUNT_B: prdata = {55'd0, cfg_q.count_b};
			REG_ENTROPY: prdata = {48'd0, cfg_q.entropy_per_wounded};
			REG_ALPHA:   prdata = {47'd0, cfg_q.binary_fraction};
			default:     prdata = 64'd0;
		endcase
	end

endmodule

[hdl/gcc_weight.sv]
// two stage entropy weight pipeline for one nucleon count
// depends on gcc_pkg
module gcc_weight (
	input  logic          clk,
	input  gcc_pkg::cfg_t cfg,
	input  logic [8:0]    n,
	output logic [23:0]   weight
);
	import gcc_pkg::*;

	logic [16:0] alpha;
	logic [26:0] inner_s1;
	logic        zero_s1;
	logic [42:0] prod_s2;
	logic        zero_s2;
	logic [25:0] shifted;

	assign alpha = (cfg.binary_fraction > ALPHA_ONE) ? ALPHA_ONE : cfg.binary_fraction;

	always_ff @(posedge clk) begin
		inner_s1 <= 27'(ALPHA_ONE - alpha) + (27'(alpha) * 27'(n));
		zero_s1  <= (n == 9'd0);
		prod_s2  <= 43'(cfg.entropy_per_wounded) * 43'(inner_s1);
		zero_s2  <= zero_s1;
	end

	assign shifted = prod_s2[42:17];
	assign weight  = zero_s2 ? 24'd0 : ((|shifted[25:24]) ? 24'hFFFFFF : shifted[23:0]);

endmodule

[hdl/gcc_checker.sv]
// port level checks for the glauber collision counter, bound to the top level
// depends on gcc_pkg and glauber_collision_counter
module gcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  opcode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [9:0]  participants,
	input logic        event_ok,
	input logic [8:0]  nucleon_collisions,
	input logic        nucleon_wounded,
	input logic [23:0] nucleon_weight
);
	import gcc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_EVENT |=> in_stall)
		else $error("event item did not hold off the input");

	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_ok == (participants != 10'd0)))
		else $error("event_ok disagrees with participants");

	a_unwounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nucleon_wounded |-> nucleon_weight == 24'd0 && nucleon_collisions == 9'd0)
		else $error("unwounded nucleon with weight or count");

endmodule

bind glauber_collision_counter gcc_checker u_gcc_checker (.*);
